// ===== sv/ultrasonic_echo_ranger_core_assert.svh =====
// ---------------------------------------------------------------------------
// ultrasonic echo ranger assertion macros
// concurrent check wrappers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define UER_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// next-cycle implication
`define UER_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`else

`define UER_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define UER_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/uer_pkg.sv =====
// ---------------------------------------------------------------------------
// uer_pkg
// widths, limits and register codes of the ultrasonic echo ranger
// ---------------------------------------------------------------------------
package uer_pkg;

  localparam int DIST_BITS      = 21;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [DIST_BITS-1:0] dist_t;

  localparam dist_t DIST_MAX       = {DIST_BITS{1'b1}};
  localparam dist_t MIN_DIST_RESET = dist_t'(2000);
  localparam dist_t MAX_DIST_RESET = dist_t'(400000);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MIN_DISTANCE = 2'd0,
    REG_MAX_DISTANCE = 2'd1
  } cfg_reg_t;

endpackage

// ===== sv/ultrasonic_echo_ranger_core.sv =====
// ---------------------------------------------------------------------------
// ultrasonic echo ranger core
// echo pulse width measurement, range gating and moving average
// ---------------------------------------------------------------------------
// usage
//   echo channel: one request per microsecond tick, carrying the sampled echo
//   pin level; echo_valid/echo_stall, taken when valid and not stall
//   result channel: one request per falling edge of the echo pulse, with the
//   gated distance (thousandths of cm), the range flag and the window mean
//   config channel: cfg_valid/cfg_ready, ready always high; index 0 is the
//   minimum distance, 1 the maximum, other indexes are dropped; write only
//   while the block holds no pending measurement
//   throughput: one tick per cycle, sustained, as long as results are taken
//   latency: a falling edge is on the result port two cycles after the edge
//   that takes it (distance register, range/window register, result
//   register loaded with the window average)
//   stall: a stalled result holds; ticks keep flowing until the three
//   measurement stages fill, then echo_stall rises
//   reset: synchronous, clears the pulse counter, edge detector, window
//   contents, running sum and all valid flags; limits go to 2000 and 400000
// ---------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_core_assert.svh"

module ultrasonic_echo_ranger_core #(
  parameter int WINDOW_DEPTH = 8,
  parameter int COUNT_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // echo tick channel
  input  logic                                 echo_valid,
  output logic                                 echo_stall,
  input  logic                                 echo_level,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output uer_pkg::dist_t                       distance,
  output logic                                 in_range,
  output uer_pkg::dist_t                       average,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [uer_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  uer_pkg::dist_t                       cfg_data
);

  import uer_pkg::*;

  // ticks * 17 is (ticks << 4) + ticks
  localparam int PROD_BITS = COUNT_BITS + 5;
  localparam int WIDE_BITS = (PROD_BITS > DIST_BITS) ? PROD_BITS : DIST_BITS + 1;

  // running sum and exact reciprocal for floor(sum / WINDOW_DEPTH)
  localparam int WIN_LOG    = $clog2(WINDOW_DEPTH);
  localparam int SUM_BITS   = DIST_BITS + WIN_LOG;
  localparam int RECIP_SHIFT = SUM_BITS + WIN_LOG;
  localparam int AVG_BITS   = 2 * SUM_BITS + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SHIFT) + longint'(WINDOW_DEPTH) - 64'd1) / longint'(WINDOW_DEPTH);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // configuration registers
  dist_t min_distance;
  dist_t max_distance;

  // edge detector and pulse counter
  logic                  last_level;
  logic [COUNT_BITS-1:0] pulse_ticks;

  // stage 1: saturated raw distance of a finished pulse
  logic  s1_valid;
  dist_t s1_raw;

  // stage 2: gated distance sits in window[0], sum in window_sum
  logic                s2_valid;
  logic                s2_ok;
  dist_t               window [WINDOW_DEPTH];
  logic [SUM_BITS-1:0] window_sum;

  // handshake plumbing
  logic echo_take;
  logic out_free;
  logic s2_move;
  logic s2_free;
  logic s1_move;
  logic s1_free;
  logic fall_edge;

  // datapath
  logic [WIDE_BITS-1:0] raw_wide;
  dist_t                raw_sat;
  logic                 range_ok;
  dist_t                dist_new;
  logic [SUM_BITS-1:0]  window_sum_next;
  logic [AVG_BITS-1:0]  avg_prod;

  assign cfg_ready = 1'b1;

  // output register frees when empty or being taken
  assign out_free   = !result_valid || !result_stall;
  assign s2_move    = s2_valid && out_free;
  assign s2_free    = !s2_valid || s2_move;
  assign s1_move    = s1_valid && s2_free;
  assign s1_free    = !s1_valid || s1_move;
  assign echo_stall = !s1_free;
  assign echo_take  = echo_valid && !echo_stall;
  assign fall_edge  = echo_take && !echo_level && last_level;

  // pulse width to distance, clipped to the field width
  always_comb begin
    raw_wide = (WIDE_BITS'(pulse_ticks) << 4) + WIDE_BITS'(pulse_ticks);
    if (raw_wide > WIDE_BITS'(DIST_MAX)) begin
      raw_sat = DIST_MAX;
    end else begin
      raw_sat = raw_wide[DIST_BITS-1:0];
    end
  end

  // limits are inclusive, out of range reads as zero
  assign range_ok        = (s1_raw >= min_distance) && (s1_raw <= max_distance);
  assign dist_new        = range_ok ? s1_raw : '0;
  assign window_sum_next = window_sum - SUM_BITS'(window[WINDOW_DEPTH-1])
                         + SUM_BITS'(dist_new);

  // floor(sum / depth) via ceiling reciprocal, exact over the sum range
  assign avg_prod = AVG_BITS'(window_sum) * AVG_BITS'(RECIP);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= MIN_DIST_RESET;
      max_distance <= MAX_DIST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_DISTANCE: min_distance <= cfg_data;
        REG_MAX_DISTANCE: max_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // edge detection and high-tick counting
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level  <= 1'b0;
      pulse_ticks <= '0;
    end else if (echo_take) begin
      last_level <= echo_level;
      if (echo_level && !last_level) begin
        pulse_ticks <= COUNT_BITS'(1);
      end else if (echo_level && (pulse_ticks != COUNT_MAX)) begin
        pulse_ticks <= pulse_ticks + COUNT_BITS'(1);
      end
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fall_edge) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fall_edge) begin
      s1_raw <= raw_sat;
    end
  end

  // stage 2: range gate and window shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid   <= 1'b0;
      s2_ok      <= 1'b0;
      window_sum <= '0;
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
        window[k] <= '0;
      end
    end else if (s1_move) begin
      s2_valid   <= 1'b1;
      s2_ok      <= range_ok;
      window_sum <= window_sum_next;
      window[0]  <= dist_new;
      for (int k = 1; k < WINDOW_DEPTH; k++) begin
        window[k] <= window[k-1];
      end
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_move) begin
      result_valid <= 1'b1;
    end else if (out_free) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      distance <= window[0];
      in_range <= s2_ok;
      average  <= avg_prod[RECIP_SHIFT +: DIST_BITS];
    end
  end

  // checks
  `UER_ASSERT_IMPLY(a_high_counts, clk, rst, last_level, pulse_ticks != '0)
  `UER_ASSERT_NEXT(a_fall_loads_s1, clk, rst, fall_edge, s1_valid)
  `UER_ASSERT_NEXT(a_s1_reaches_s2, clk, rst, s1_move, s2_valid)
  `UER_ASSERT_IMPLY(a_gate_zero, clk, rst, s2_valid && !s2_ok, window[0] == '0)
  `UER_ASSERT_IMPLY(a_out_zero, clk, rst, result_valid && !in_range, distance == '0)

endmodule

// ===== tb/sv/tb_ultrasonic_echo_ranger_core.sv =====
// ---------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger_core
// drives echo pin ticks through the ranger core with random pacing on both
// channels, predicts every pulse measurement (range gate and moving average)
// in a local model and checks each result field by field, in order
// ---------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger_core;
  import uer_pkg::*;

  localparam int          WIN_DEPTH     = 8;
  localparam int          TICK_BITS     = 16;
  localparam int unsigned CM_PER_TICK   = 17;   // thousandths of cm per microsecond
  localparam int unsigned MAX_WAIT      = 13;
  localparam int unsigned SETTLE_CYCLES = 8;    // 3-stage pipe plus margin
  localparam int unsigned IDLE_LIMIT    = 1000;
  localparam int unsigned RAND_PHASES   = 6;
  localparam int unsigned PHASE_TICKS   = 30;

  localparam logic [TICK_BITS-1:0] TICK_CEIL = {TICK_BITS{1'b1}};

  // indexes with no register behind them
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    dist_t distance;
    logic  in_range;
    dist_t average;
  } range_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      echo_valid = 1'b0;
  logic                      echo_stall;
  logic                      echo_level = 1'b0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  dist_t                     distance;
  logic                      in_range;
  dist_t                     average;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_MIN_DISTANCE;
  dist_t                     cfg_data = '0;

  // pending echo ticks and expected measurements
  bit            tick_queue[$];
  range_result_t pending_ranges[$];

  // local copy of the ranger state and limits
  logic                 prev_level   = 1'b0;
  logic [TICK_BITS-1:0] high_ticks   = '0;
  dist_t                window_q [WIN_DEPTH] = '{default: '0};
  logic [2:0]           slot_ptr     = '0;
  logic [23:0]          window_total = '0;
  dist_t                lim_lo       = MIN_DIST_RESET;
  dist_t                lim_hi       = MAX_DIST_RESET;

  // pacing: mode 0 back to back, 1 full random, 2 rare gaps
  bit          pace_flat    = 1'b0;
  int          src_mode     = 1;
  int          sink_mode    = 1;
  int unsigned echo_gap     = 0;
  int unsigned result_hold  = 0;
  bit          echo_taken   = 1'b0;
  bit          result_taken = 1'b0;
  int unsigned idle_cycles  = 0;
  int unsigned fail_count   = 0;

  ultrasonic_echo_ranger_core dut (
    .clk          (clk),
    .rst          (rst),
    .echo_valid   (echo_valid),
    .echo_stall   (echo_stall),
    .echo_level   (echo_level),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .distance     (distance),
    .in_range     (in_range),
    .average      (average),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int unsigned draw_wait(int mode);
    if (pace_flat || mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, MAX_WAIT);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
  endfunction

  // one microsecond tick of the ranger: edge detect, count, gate, average
  function automatic void predict_tick(logic level);
    logic [31:0]   product;
    dist_t         meas;
    logic          ok;
    range_result_t res;
    if (level && !prev_level) begin
      high_ticks = TICK_BITS'(1);
    end else if (level) begin
      // counter holds at its ceiling on very long pulses
      if (high_ticks != TICK_CEIL) high_ticks++;
    end else if (prev_level) begin
      // falling edge closes the pulse: one measurement
      product = 32'(high_ticks) * CM_PER_TICK;
      if (product > 32'(DIST_MAX)) product = 32'(DIST_MAX);
      meas = dist_t'(product);
      // both limits inclusive; min above max rejects everything
      ok = (meas >= lim_lo) && (meas <= lim_hi);
      if (!ok) meas = '0;
      // newest replaces oldest, zero measurements included
      window_total = window_total - 24'(window_q[slot_ptr]) + 24'(meas);
      window_q[slot_ptr] = meas;
      slot_ptr++;
      res.distance = meas;
      res.in_range = ok;
      res.average  = dist_t'(window_total / WIN_DEPTH);
      pending_ranges.push_back(res);
    end
    prev_level = level;
  endfunction

  function automatic void push_pulse(int unsigned high_len, int unsigned low_len);
    repeat (high_len) tick_queue.push_back(1'b1);
    repeat (low_len) tick_queue.push_back(1'b0);
  endfunction

  // register write, only called while the core holds nothing in flight
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input dist_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_DISTANCE: lim_lo = value;
      REG_MAX_DISTANCE: lim_hi = value;
      default: ;   // unknown index, dropped by the core
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for all ticks sent and all measurements back, then let the pipe empty
  task automatic settle();
    do @(posedge clk);
    while (tick_queue.size() != 0 || echo_valid || pending_ranges.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // tick request accepted: advance the local model
  always @(posedge clk) begin
    echo_taken = !rst && echo_valid && !echo_stall;
    if (echo_taken) predict_tick(echo_level);
  end

  // tick driver: holds a stalled request, otherwise waits out its gap
  always @(negedge clk) begin
    if (rst) begin
      echo_valid <= 1'b0;
      echo_level <= 1'b0;
    end else if (!echo_valid || echo_taken) begin
      if (echo_gap != 0) begin
        echo_gap--;
        echo_valid <= 1'b0;
      end else if (tick_queue.size() != 0) begin
        echo_level <= tick_queue.pop_front();
        echo_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) src_mode = $urandom_range(0, 2);
        echo_gap = draw_wait(src_mode);
      end else begin
        echo_valid <= 1'b0;
      end
    end
  end

  // result monitor: compare against the oldest expected measurement
  always @(posedge clk) begin : result_check
    range_result_t want;
    result_taken = 1'b0;
    if (!rst && result_valid && !result_stall) begin
      result_taken = 1'b1;
      if (pending_ranges.size() == 0) begin
        $display("%0t: unexpected result: distance %0d in_range %0b average %0d",
                 $time, distance, in_range, average);
        fail_count++;
      end else begin
        want = pending_ranges.pop_front();
        if (distance !== want.distance) begin
          $display("%0t: distance mismatch: expected %0d, actual %0d",
                   $time, want.distance, distance);
          fail_count++;
        end
        if (in_range !== want.in_range) begin
          $display("%0t: in_range mismatch: expected %0b, actual %0b",
                   $time, want.in_range, in_range);
          fail_count++;
        end
        if (average !== want.average) begin
          $display("%0t: average mismatch: expected %0d, actual %0d",
                   $time, want.average, average);
          fail_count++;
        end
      end
    end
  end

  // result side back-pressure, a fresh stall drawn after every request taken
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_taken) begin
        if ($urandom_range(0, 15) == 0) sink_mode = $urandom_range(0, 2);
        result_hold = draw_wait(sink_mode);
      end
      if (result_hold != 0) begin
        result_hold--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // watchdog: no request moving on any channel for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((echo_valid && !echo_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_ultrasonic_echo_ranger_core: FAIL");
        $finish;
      end
    end
  end

  initial begin
    dist_t lo;
    dist_t hi;
    int unsigned pick;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset limits 2000..400000: 117 ticks just below, 118 just inside
    tick_queue.push_back(1'b0);
    push_pulse(117, 2);
    push_pulse(118, 1);
    settle();

    // limits on exact tick multiples, equality at both ends
    write_reg(REG_MIN_DISTANCE, dist_t'(2 * CM_PER_TICK));
    write_reg(REG_MAX_DISTANCE, dist_t'(3 * CM_PER_TICK));
    write_reg(REG_SPARE_A, DIST_MAX);
    write_reg(REG_SPARE_B, '0);
    for (int unsigned n = 1; n <= 4; n++) push_pulse(n, 1);
    settle();

    // minimum above maximum: nothing passes
    write_reg(REG_MIN_DISTANCE, DIST_MAX);
    write_reg(REG_MAX_DISTANCE, '0);
    push_pulse(2, 1);
    push_pulse(3, 2);
    push_pulse(1, 1);
    settle();

    // full range, ticks back to back
    write_reg(REG_MIN_DISTANCE, '0);
    write_reg(REG_MAX_DISTANCE, DIST_MAX);
    pace_flat = 1'b1;
    push_pulse(1, 1);
    push_pulse(40, 2);
    settle();
    pace_flat = 1'b0;

    // random phases: new limits, then mostly clean pulses with some noise
    repeat (RAND_PHASES) begin
      pick = $urandom_range(0, 4);
      case (pick)
        0: begin
          lo = dist_t'(CM_PER_TICK * $urandom_range(0, 6));
          hi = dist_t'(CM_PER_TICK * $urandom_range(6, 20));
        end
        1: begin
          lo = dist_t'($urandom_range(0, 400));
          hi = dist_t'($urandom_range(0, 400));
        end
        2: begin
          lo = '0;
          hi = DIST_MAX;
        end
        3: begin
          lo = dist_t'($urandom);
          hi = dist_t'($urandom);
        end
        default: begin
          // single accepted point
          lo = dist_t'(CM_PER_TICK * $urandom_range(1, 20));
          hi = lo;
        end
      endcase
      write_reg(REG_MIN_DISTANCE, lo);
      write_reg(REG_MAX_DISTANCE, hi);
      while (tick_queue.size() < PHASE_TICKS) begin
        if ($urandom_range(0, 4) != 0)
          push_pulse($urandom_range(1, 20), $urandom_range(1, 4));
        else
          repeat ($urandom_range(1, 6)) tick_queue.push_back(1'($urandom));
      end
      settle();
    end

    if (fail_count == 0)
      $display("tb_ultrasonic_echo_ranger_core: PASS");
    else
      $display("tb_ultrasonic_echo_ranger_core: FAIL");
    $finish;
  end

endmodule

// ===== ultrasonic_echo_ranger_core.f =====
+incdir+sv
sv/uer_pkg.sv
sv/ultrasonic_echo_ranger_core.sv
tb/sv/tb_ultrasonic_echo_ranger_core.sv
